/* src/tcpaf_pkg.sv */
// Shared types and constants for the tree closest-pair average filter.
package tcpaf_pkg;

  localparam int CFG_WIDTH = 3;
  localparam int CNT_WIDTH = 2;

  localparam logic [CFG_WIDTH-1:0] LEVELS_RESET = 3'd1;

  localparam logic [CNT_WIDTH-1:0] CNT_EMPTY = 2'd0;
  localparam logic [CNT_WIDTH-1:0] CNT_ONE   = 2'd1;
  localparam logic [CNT_WIDTH-1:0] CNT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } state_t;

endpackage

/* src/tcpaf_reduce3.sv */
// Three-way closest-pair reducer: averages the pair with the smallest difference.
module tcpaf_reduce3 #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0] a0,
  input  logic signed [SAMPLE_WIDTH-1:0] a1,
  input  logic signed [SAMPLE_WIDTH-1:0] a2,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  logic signed [SAMPLE_WIDTH:0] e0, e1, e2;
  logic signed [SAMPLE_WIDTH:0] s01, s12, s20;
  logic        [SAMPLE_WIDTH-1:0] d01, d12, d20;
  logic signed [SAMPLE_WIDTH:0] pa, pb, sum;

  assign e0 = {a0[SAMPLE_WIDTH-1], a0};
  assign e1 = {a1[SAMPLE_WIDTH-1], a1};
  assign e2 = {a2[SAMPLE_WIDTH-1], a2};

  assign s01 = e0 - e1;
  assign s12 = e1 - e2;
  assign s20 = e2 - e0;

  assign d01 = s01[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-s01) : s01[SAMPLE_WIDTH-1:0];
  assign d12 = s12[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-s12) : s12[SAMPLE_WIDTH-1:0];
  assign d20 = s20[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-s20) : s20[SAMPLE_WIDTH-1:0];

  always_comb begin
    pa = e0;
    pb = e2;
    priority if (d01 < d12) begin
      if (d01 < d20) begin
        pa = e0;
        pb = e1;
      end
    end else if (d12 < d20) begin
      pa = e1;
      pb = e2;
    end
  end

  assign sum    = pa + pb;
  assign result = sum[SAMPLE_WIDTH:1];

endmodule

/* src/tree_closest_pair_average_filter_core.sv */
// Top level of the tree closest-pair average filter core.
// Each sample transfer is reduced level by level through one shared three-way
// reducer, one tree level per cycle. A sample that only fills a level slot is
// accepted and stored at its level; one that completes a group at every level
// is accepted, reduced at each level in turn and then loaded into the output
// register. Loading the output register also waits while an earlier result
// is still held there. One filtered result is sent per window of
// 3^levels_in_use samples; levels_in_use of 0 acts as 1 and values above
// MAX_LEVELS act as MAX_LEVELS. cfg_ready is high only while no sample is
// being reduced, and writing levels_in_use restarts the window with the next
// sample.
module tree_closest_pair_average_filter_core #(
  parameter int MAX_LEVELS   = 5,
  parameter int SAMPLE_WIDTH = 16,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcpaf_pkg::CFG_WIDTH-1:0] cfg_data,   // levels_in_use
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [TDATA_W-1:0]               s_tdata,    // sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [TDATA_W-1:0]               m_tdata     // filtered
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  tcpaf_pkg::state_t state, state_next;

  logic [tcpaf_pkg::CFG_WIDTH-1:0] levels;
  logic [LVL_W-1:0]                lvl;
  logic [LVL_W-1:0]                lvl_last;
  logic [SAMPLE_WIDTH-1:0]         v;
  logic [SAMPLE_WIDTH-1:0]         h0 [MAX_LEVELS];
  logic [SAMPLE_WIDTH-1:0]         h1 [MAX_LEVELS];
  logic [tcpaf_pkg::CNT_WIDTH-1:0] cnt [MAX_LEVELS];
  logic [tcpaf_pkg::CNT_WIDTH-1:0] cnt_cur;
  logic signed [SAMPLE_WIDTH-1:0]  red_out;
  logic                            load_out;
  logic                            in_xfer;
  logic                            cfg_xfer;

  assign cfg_ready = (state == tcpaf_pkg::ST_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = s_tvalid && s_tready;
  assign cnt_cur   = cnt[lvl];

  always_comb begin
    if (levels == '0) begin
      lvl_last = '0;
    end else if (int'(levels) > MAX_LEVELS) begin
      lvl_last = LVL_W'(MAX_LEVELS - 1);
    end else begin
      lvl_last = LVL_W'(int'(levels) - 1);
    end
  end

  tcpaf_reduce3 #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_reduce (
    .a0    ($signed(h0[lvl])),
    .a1    ($signed(h1[lvl])),
    .a2    ($signed(v)),
    .result(red_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      tcpaf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = tcpaf_pkg::ST_RUN;
        end
      end
      tcpaf_pkg::ST_RUN: begin
        if (cnt_cur != tcpaf_pkg::CNT_FULL) begin
          state_next = tcpaf_pkg::ST_IDLE;
        end else if (lvl == lvl_last) begin
          state_next = tcpaf_pkg::ST_PUSH;
        end
      end
      tcpaf_pkg::ST_PUSH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = tcpaf_pkg::ST_IDLE;
        end
      end
      default: state_next = tcpaf_pkg::ST_IDLE;
    endcase
  end

  // datapath: working value, level pointer, held values
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      v   <= s_tdata[SAMPLE_WIDTH-1:0];
      lvl <= '0;
    end else if (state == tcpaf_pkg::ST_RUN) begin
      case (cnt_cur)
        tcpaf_pkg::CNT_EMPTY: h0[lvl] <= v;
        tcpaf_pkg::CNT_ONE:   h1[lvl] <= v;
        tcpaf_pkg::CNT_FULL: begin
          v   <= red_out;
          lvl <= lvl + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // control: register, level counts
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= tcpaf_pkg::LEVELS_RESET;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        cnt[i] <= tcpaf_pkg::CNT_EMPTY;
      end
    end else if (cfg_xfer) begin
      levels <= cfg_data;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        cnt[i] <= tcpaf_pkg::CNT_EMPTY;
      end
    end else if (state == tcpaf_pkg::ST_RUN) begin
      if (cnt_cur == tcpaf_pkg::CNT_FULL) begin
        cnt[lvl] <= tcpaf_pkg::CNT_EMPTY;
      end else begin
        cnt[lvl] <= cnt_cur + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= TDATA_W'(v);
    end
  end

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == tcpaf_pkg::ST_RUN)
    else $error("accepted sample did not start a reduction");

  a_lvl_bound: assert property (@(posedge clk) disable iff (rst)
    state == tcpaf_pkg::ST_RUN |-> lvl <= lvl_last)
    else $error("level pointer ran past the tree depth");

  a_cnt_legal: assert property (@(posedge clk) disable iff (rst)
    state == tcpaf_pkg::ST_RUN |-> cnt_cur != 2'd3)
    else $error("level count out of range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == tcpaf_pkg::ST_PUSH)
    else $error("result appeared without a completed window");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    state == tcpaf_pkg::ST_RUN && cnt_cur == tcpaf_pkg::CNT_FULL && lvl == lvl_last
    |=> state == tcpaf_pkg::ST_PUSH)
    else $error("root reduction did not reach output stage");

endmodule

/* dv/tb_tree_closest_pair_average_filter_core.sv */
// Self-checking testbench for the tree closest-pair average filter core.
module tb_tree_closest_pair_average_filter_core;

  localparam int SW    = 16;
  localparam int MAXL  = 5;
  localparam int ITEMS = 1800;
  localparam int DRAIN = 12;
  localparam int LIMIT = 2000;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic signed [SW-1:0]  value;
    bit                    known;
    logic signed [SW-1:0]  result;
  } stim_row_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [tcpaf_pkg::CFG_WIDTH-1:0]      cfg_data;
  logic                                 s_tvalid;
  logic                                 s_tready;
  logic [SW-1:0]                        s_tdata;   // sample
  logic                                 m_tvalid;
  logic                                 m_tready;
  logic [SW-1:0]                        m_tdata;   // filtered

  // filter image
  logic [tcpaf_pkg::CFG_WIDTH-1:0] levels_cfg;
  logic signed [SW-1:0]            held_vals [2*MAXL];
  logic [tcpaf_pkg::CNT_WIDTH-1:0] fill_cnt [MAXL];
  logic [SW-1:0]                   pending_filtered [$];
  logic [SW-1:0]                   oldest_filtered;

  bit calm = 1'b0;
  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  // reset config is levels_in_use = 1, so every three samples close a window
  stim_row_t plan [31] = '{
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh8000, 1'b1, 16'sh8000},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd0,    1'b1, 16'sd16383},
    '{ROW_SAMPLE, 16'sd0,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd4,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd2,    1'b1, 16'sd1},
    '{ROW_SAMPLE, 16'sd0,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd2,    1'b0, 16'sd0},
    '{ROW_SAMPLE, -16'sd2,   1'b1, -16'sd1},
    '{ROW_SAMPLE, -16'sd1,   1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd0,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd100,  1'b1, -16'sd1},
    '{ROW_CFG,    16'sd0,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd10,   1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd20,   1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd60,   1'b1, 16'sd15},
    '{ROW_SAMPLE, 16'sd100,  1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd200,  1'b0, 16'sd0},
    '{ROW_CFG,    16'sd1,    1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd7,    1'b0, 16'sd0},
    '{ROW_SAMPLE, -16'sd9,   1'b0, 16'sd0},
    '{ROW_SAMPLE, 16'sd30,   1'b0, 16'sd0}
  };

  logic [tcpaf_pkg::CFG_WIDTH-1:0] level_sweep [8] =
    '{3'd1, 3'd5, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd6};

  tree_closest_pair_average_filter_core #(
    .MAX_LEVELS  (MAXL),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int tree_depth(input logic [tcpaf_pkg::CFG_WIDTH-1:0] lv);
    if (lv == 0) return 1;
    if (lv > MAXL) return MAXL;
    return int'(lv);
  endfunction

  function automatic logic signed [SW-1:0] closest_pair_avg(
    input logic signed [SW-1:0] a0, a1, a2);
    int x0, x1, x2, d01, d12, d20, sum;
    x0 = a0;
    x1 = a1;
    x2 = a2;
    d01 = (x0 > x1) ? x0 - x1 : x1 - x0;
    d12 = (x1 > x2) ? x1 - x2 : x2 - x1;
    d20 = (x2 > x0) ? x2 - x0 : x0 - x2;
    if (d01 < d12) sum = (d01 < d20) ? x0 + x1 : x0 + x2;
    else           sum = (d12 < d20) ? x1 + x2 : x0 + x2;
    return SW'(sum >>> 1);
  endfunction

  // walk the sample up the tree; root set when a whole window closes
  task automatic advance_tree(input logic signed [SW-1:0] v, output bit done,
                              output logic signed [SW-1:0] root);
    int depth;
    logic signed [SW-1:0] carry;
    depth = tree_depth(levels_cfg);
    carry = v;
    done  = 1'b0;
    root  = '0;
    for (int lvl = 0; lvl < depth; lvl++) begin
      if (fill_cnt[lvl] != tcpaf_pkg::CNT_FULL) begin
        held_vals[2*lvl + int'(fill_cnt[lvl])] = carry;
        fill_cnt[lvl] = fill_cnt[lvl] + 1'b1;
        return;
      end
      carry = closest_pair_avg(held_vals[2*lvl], held_vals[2*lvl+1], carry);
      fill_cnt[lvl] = tcpaf_pkg::CNT_EMPTY;
    end
    done = 1'b1;
    root = carry;
  endtask

  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
               $signed(want), $time);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic signed [SW-1:0] v, input bit known,
                             input logic signed [SW-1:0] known_val);
    bit done;
    logic signed [SW-1:0] root;
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    do @(posedge clk); while (!s_tready);
    advance_tree(v, done, root);
    if (done) pending_filtered.push_back(known ? known_val : root);
    samples_sent++;
    @(negedge clk);
  endtask

  // only once the block has drained
  task automatic write_levels(input logic [tcpaf_pkg::CFG_WIDTH-1:0] lv);
    s_tvalid = 1'b0;
    while (pending_filtered.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = lv;
    do @(posedge clk); while (!cfg_ready);
    levels_cfg = lv;
    foreach (fill_cnt[i]) fill_cnt[i] = tcpaf_pkg::CNT_EMPTY;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [SW-1:0] next_sample(input logic signed [SW-1:0] base);
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:          return r[0] ? 16'sh7FFF : 16'sh8000;
      1, 2, 3, 4: return r[SW-1:0];
      default:    return base + {{(SW-3){r[2]}}, r[2:0]};
    endcase
  endfunction

  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 20);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_filtered.size() == 0) begin
        report_mismatch("unexpected filtered transfer", m_tdata, '0);
      end else begin
        oldest_filtered = pending_filtered.pop_front();
        results_seen++;
        if (m_tdata !== oldest_filtered)
          report_mismatch("filtered", m_tdata, oldest_filtered);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [tcpaf_pkg::CFG_WIDTH-1:0] lv;
    logic signed [SW-1:0] base;
    int phase, depth, window, windows, count, pick;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    levels_cfg = tcpaf_pkg::LEVELS_RESET;
    foreach (held_vals[i]) held_vals[i] = '0;
    foreach (fill_cnt[i]) fill_cnt[i] = tcpaf_pkg::CNT_EMPTY;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_levels(plan[i].value[tcpaf_pkg::CFG_WIDTH-1:0]);
      else send_sample(plan[i].value, plan[i].known, plan[i].result);
    end

    phase = 0;
    while (samples_sent < ITEMS) begin
      if (phase < 8) begin
        lv = level_sweep[phase];
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      lv = tcpaf_pkg::CFG_WIDTH'($urandom_range(2));
        else if (pick < 95) lv = 3'd3;
        else                lv = tcpaf_pkg::CFG_WIDTH'($urandom_range(7, 4));
      end
      write_levels(lv);
      calm = (phase == 3) || (phase > 8 && $urandom_range(9) == 0);
      depth   = tree_depth(lv);
      window  = 3 ** depth;
      windows = (depth <= 2) ? $urandom_range(12, 1) : (depth == 3) ? $urandom_range(3, 1) : 1;
      count   = windows * window;
      // sometimes leave a partial window for the next write to discard
      if ($urandom_range(2) == 0) count += $urandom_range(window - 1);
      if (count > ITEMS - samples_sent) count = ITEMS - samples_sent;
      base = SW'($urandom());
      repeat (count) send_sample(next_sample(base), 1'b0, '0);
      calm = 1'b0;
      phase++;
    end

    s_tvalid = 1'b0;
    while (pending_filtered.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Run covered %0d samples and %0d filtered results", samples_sent, results_seen);
    $display("across %0d levels_in_use writes spanning values 0 through 7", cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
